@@ rtl/fat_block_chain_allocator_assert.svh @@
// assertion macros for the allocation table allocator
// depends on nothing; included by fbca_seq, the module that carries assertions
`ifndef FAT_BLOCK_CHAIN_ALLOCATOR_ASSERT_SVH
`define FAT_BLOCK_CHAIN_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define FBCA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FBCA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/fbca_pkg.sv @@
// shared types, codes and helpers of the allocation table allocator
// depends on nothing
package fbca_pkg;

   localparam int ADDR_W     = 16;
   localparam int NUM_BLOCKS = 8192;
   localparam int IDX_W      = $clog2(NUM_BLOCKS);
   localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);
   localparam int ENT_W      = IDX_W + 2;
   localparam int KIND_W     = 3;
   localparam int ST_W       = 2;
   localparam int FREED_W    = 14;

   localparam logic [ADDR_W-1:0] DATA_BASE_RESET = 16'd512;

   // entry tags
   localparam logic [1:0] TAG_FREE = 2'd0;
   localparam logic [1:0] TAG_END  = 2'd1;
   localparam logic [1:0] TAG_LINK = 2'd2;

   // request kinds
   localparam logic [KIND_W-1:0] REQ_START  = 3'd0;
   localparam logic [KIND_W-1:0] REQ_APPEND = 3'd1;
   localparam logic [KIND_W-1:0] REQ_FREE   = 3'd2;
   localparam logic [KIND_W-1:0] REQ_NEXT   = 3'd3;
   localparam logic [KIND_W-1:0] REQ_FORMAT = 3'd4;

   // status codes
   localparam logic [ST_W-1:0] ST_OK      = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
   localparam logic [ST_W-1:0] ST_RANGE   = 2'd2;
   localparam logic [ST_W-1:0] ST_UNALLOC = 2'd3;

   typedef struct packed {
      logic [1:0]       tag;
      logic [IDX_W-1:0] link;
   } entry_type;

   typedef struct packed {
      logic [ST_W-1:0]    status;
      logic [ADDR_W-1:0]  addr;
      logic               chain_end;
      logic [FREED_W-1:0] freed;
   } rsp_type;

   function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] idx,
                                                 input logic [ADDR_W-1:0] base);
      logic [ADDR_W-1:0] wide;
      wide = ADDR_W'(idx);
      return wide + base;
   endfunction

endpackage

@@ rtl/fbca_ram.sv @@
// generic simple dual-port ram, one write and one registered read per cycle
// depends on nothing
module fbca_ram #(
   parameter int DEPTH = 8192,
   parameter int WIDTH = 15
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/fbca_seq.sv @@
// request sequencer: clearing sweep, first-fit scan, chain walk and format
// depends on fbca_pkg and fat_block_chain_allocator_assert.svh
`include "fat_block_chain_allocator_assert.svh"

module fbca_seq (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [fbca_pkg::KIND_W-1:0]      req_kind,
   input  logic [fbca_pkg::ADDR_W-1:0]      req_addr,
   input  logic [fbca_pkg::ADDR_W-1:0]      data_base,
   output logic                             ram_we,
   output logic [fbca_pkg::IDX_W-1:0]       ram_waddr,
   output logic [fbca_pkg::ENT_W-1:0]       ram_wdata,
   output logic                             ram_re,
   output logic [fbca_pkg::IDX_W-1:0]       ram_raddr,
   input  logic [fbca_pkg::ENT_W-1:0]       ram_rdata,
   output logic                             rsp_valid,
   input  logic                             rsp_take,
   output fbca_pkg::rsp_type                rsp
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_DISP  = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_LOOK  = 3'd4;
   localparam logic [2:0] S_LINKW = 3'd5;
   localparam logic [2:0] S_WALK  = 3'd6;
   localparam logic [2:0] S_FMT   = 3'd7;
   localparam logic [3:0] S_LINK  = 4'd8;
   localparam logic [3:0] S_RESP  = 4'd9;

   localparam logic [fbca_pkg::CNT_W-1:0] CNT_END  = fbca_pkg::CNT_W'(fbca_pkg::NUM_BLOCKS);
   localparam logic [fbca_pkg::CNT_W-1:0] CNT_LAST =
      fbca_pkg::CNT_W'(fbca_pkg::NUM_BLOCKS - 1);

   logic [3:0]                        state_ff, state_in;
   logic [fbca_pkg::KIND_W-1:0]       kind_ff, kind_in;
   logic [fbca_pkg::ADDR_W-1:0]       addr_ff, addr_in;
   logic [fbca_pkg::IDX_W-1:0]        idx_ff, idx_in;
   logic [fbca_pkg::IDX_W-1:0]        fnd_ff, fnd_in;
   logic [fbca_pkg::IDX_W-1:0]        chk_ff, chk_in;
   logic [fbca_pkg::CNT_W-1:0]        ptr_ff, ptr_in;
   logic                              pend_ff, pend_in;
   logic [fbca_pkg::ST_W-1:0]         st_ff, st_in;
   logic [fbca_pkg::ADDR_W-1:0]       res_ff, res_in;
   logic                              cend_ff, cend_in;
   logic [fbca_pkg::FREED_W-1:0]      freed_ff, freed_in;

   logic [fbca_pkg::ADDR_W:0]         xl_diff;
   logic                              xl_ok;
   logic [fbca_pkg::IDX_W-1:0]        xl_idx;
   fbca_pkg::entry_type               rd_ent;
   fbca_pkg::entry_type               wr_ent;

   // disk address to table index
   assign xl_diff = {1'b0, addr_ff} - {1'b0, data_base};
   assign xl_ok   = !xl_diff[fbca_pkg::ADDR_W] &&
                    (xl_diff[fbca_pkg::ADDR_W-1:0] <
                     fbca_pkg::ADDR_W'(fbca_pkg::NUM_BLOCKS));
   assign xl_idx  = xl_diff[fbca_pkg::IDX_W-1:0];

   assign rd_ent    = fbca_pkg::entry_type'(ram_rdata);
   assign ram_wdata = wr_ent;

   assign req_ready = (state_ff == {1'b0, S_IDLE});
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp.status    = st_ff;
   assign rsp.addr      = res_ff;
   assign rsp.chain_end = cend_ff;
   assign rsp.freed     = freed_ff;

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      addr_in  = addr_ff;
      idx_in   = idx_ff;
      fnd_in   = fnd_ff;
      chk_in   = chk_ff;
      ptr_in   = ptr_ff;
      pend_in  = 1'b0;
      st_in    = st_ff;
      res_in   = res_ff;
      cend_in  = cend_ff;
      freed_in = freed_ff;
      ram_re    = 1'b0;
      ram_raddr = idx_ff;
      ram_we    = 1'b0;
      ram_waddr = idx_ff;
      wr_ent.tag  = fbca_pkg::TAG_FREE;
      wr_ent.link = '0;
      case (state_ff)
         {1'b0, S_CLEAR}: begin
            ram_we    = 1'b1;
            ram_waddr = ptr_ff[fbca_pkg::IDX_W-1:0];
            if (ptr_ff == CNT_LAST) begin
               state_in = {1'b0, S_IDLE};
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         {1'b0, S_IDLE}: begin
            if (req_valid) begin
               kind_in  = req_kind;
               addr_in  = req_addr;
               state_in = {1'b0, S_DISP};
            end
         end
         {1'b0, S_DISP}: begin
            idx_in   = xl_idx;
            ptr_in   = '0;
            st_in    = fbca_pkg::ST_OK;
            res_in   = '0;
            cend_in  = 1'b0;
            freed_in = '0;
            case (kind_ff)
               fbca_pkg::REQ_START: begin
                  state_in = {1'b0, S_SCAN};
               end
               fbca_pkg::REQ_APPEND, fbca_pkg::REQ_FREE, fbca_pkg::REQ_NEXT: begin
                  if (!xl_ok) begin
                     st_in    = fbca_pkg::ST_RANGE;
                     state_in = S_RESP;
                  end else begin
                     ram_re    = 1'b1;
                     ram_raddr = xl_idx;
                     state_in  = {1'b0, S_LOOK};
                  end
               end
               fbca_pkg::REQ_FORMAT: begin
                  state_in = {1'b0, S_FMT};
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         {1'b0, S_SCAN}: begin
            // reads are pipelined: chk_ff names the entry whose data is back now
            if (pend_ff && rd_ent.tag == fbca_pkg::TAG_FREE) begin
               ram_we     = 1'b1;
               ram_waddr  = chk_ff;
               wr_ent.tag = fbca_pkg::TAG_END;
               fnd_in     = chk_ff;
               if (kind_ff == fbca_pkg::REQ_APPEND) begin
                  state_in = {1'b0, S_LINKW};
               end else begin
                  res_in   = fbca_pkg::to_addr(chk_ff, data_base);
                  cend_in  = 1'b1;
                  state_in = S_RESP;
               end
            end else if (ptr_ff == CNT_END) begin
               if (!pend_ff) begin
                  st_in    = fbca_pkg::ST_FULL;
                  state_in = S_RESP;
               end
            end else begin
               ram_re    = 1'b1;
               ram_raddr = ptr_ff[fbca_pkg::IDX_W-1:0];
               chk_in    = ptr_ff[fbca_pkg::IDX_W-1:0];
               pend_in   = 1'b1;
               ptr_in    = ptr_ff + 1'b1;
            end
         end
         {1'b0, S_LOOK}: begin
            if (rd_ent.tag == fbca_pkg::TAG_FREE) begin
               st_in    = fbca_pkg::ST_UNALLOC;
               state_in = S_RESP;
            end else if (kind_ff == fbca_pkg::REQ_FREE) begin
               // read word still held, the walk starts on it
               state_in = {1'b0, S_WALK};
            end else if (rd_ent.tag == fbca_pkg::TAG_END) begin
               if (kind_ff == fbca_pkg::REQ_NEXT) begin
                  res_in   = addr_ff;
                  cend_in  = 1'b1;
                  state_in = S_RESP;
               end else begin
                  state_in = {1'b0, S_SCAN};
               end
            end else begin
               res_in    = fbca_pkg::to_addr(rd_ent.link, data_base);
               ram_re    = 1'b1;
               ram_raddr = rd_ent.link;
               state_in  = S_LINK;
            end
         end
         S_LINK: begin
            cend_in  = (rd_ent.tag == fbca_pkg::TAG_END);
            state_in = S_RESP;
         end
         {1'b0, S_LINKW}: begin
            ram_we      = 1'b1;
            ram_waddr   = idx_ff;
            wr_ent.tag  = fbca_pkg::TAG_LINK;
            wr_ent.link = fnd_ff;
            res_in      = fbca_pkg::to_addr(fnd_ff, data_base);
            cend_in     = 1'b1;
            state_in    = S_RESP;
         end
         {1'b0, S_WALK}: begin
            if (rd_ent.tag == fbca_pkg::TAG_FREE) begin
               // stale link into a free entry ends the walk
               res_in   = addr_ff;
               state_in = S_RESP;
            end else begin
               ram_we    = 1'b1;
               ram_waddr = idx_ff;
               freed_in  = freed_ff + 1'b1;
               if (rd_ent.tag == fbca_pkg::TAG_END) begin
                  res_in   = addr_ff;
                  state_in = S_RESP;
               end else begin
                  idx_in    = rd_ent.link;
                  ram_re    = 1'b1;
                  ram_raddr = rd_ent.link;
               end
            end
         end
         {1'b0, S_FMT}: begin
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = chk_ff;
               if (rd_ent.tag != fbca_pkg::TAG_FREE) begin
                  freed_in = freed_ff + 1'b1;
               end
            end
            if (ptr_ff != CNT_END) begin
               ram_re    = 1'b1;
               ram_raddr = ptr_ff[fbca_pkg::IDX_W-1:0];
               chk_in    = ptr_ff[fbca_pkg::IDX_W-1:0];
               pend_in   = 1'b1;
               ptr_in    = ptr_ff + 1'b1;
            end else if (!pend_ff) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_take) begin
               state_in = {1'b0, S_IDLE};
            end
         end
         default: begin
            state_in = {1'b0, S_IDLE};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= {1'b0, S_CLEAR};
         ptr_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      addr_ff  <= addr_in;
      idx_ff   <= idx_in;
      fnd_ff   <= fnd_in;
      chk_ff   <= chk_in;
      st_ff    <= st_in;
      res_ff   <= res_in;
      cend_ff  <= cend_in;
      freed_ff <= freed_in;
   end

   `FBCA_ASSERT_IMP(a_no_rw_same_entry, clock, reset, ram_re && ram_we, ram_raddr != ram_waddr, "read and write hit the same entry")
   `FBCA_ASSERT_NXT(a_accept_dispatch, clock, reset, req_valid && req_ready, state_ff == 4'(S_DISP), "accepted word not dispatched")
   `FBCA_ASSERT_IMP(a_error_clean, clock, reset, rsp_valid && rsp.status != fbca_pkg::ST_OK, rsp.addr == '0 && !rsp.chain_end && rsp.freed == '0, "error result carries payload")
   `FBCA_ASSERT_IMP(a_idle_no_write, clock, reset, state_ff == {1'b0, S_IDLE}, !ram_we, "table written while idle")

endmodule

@@ rtl/fat_block_chain_allocator.sv @@
// A file allocation table allocator over fbca_pkg::NUM_BLOCKS entries kept in one
// single-port-read, single-port-write ram with a registered read. After reset the
// table is swept to all free with req_tready low; csr writes are taken throughout.
// A next lookup reads the entry and at most one link, free walks the chain block by
// block until a chain end or a stale link, start, and append at a chain end, scan
// for the first free entry from index 0, and format sweeps every entry. One request
// is worked at a time; a new one is accepted while the previous result still waits
// in the output register.
// depends on fbca_pkg, fbca_ram and fbca_seq
module fat_block_chain_allocator (
   input  logic        clock,
   input  logic        reset,
   // request words
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // block_addr[15:0]
   input  logic [2:0]  req_tuser,   // req_type[2:0]
   // result words
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // result_addr[15:0], chain_end[16], freed_count[30:17]
   output logic [1:0]  rsp_tuser,   // status[1:0]
   // data base register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_wdata
);

   logic [fbca_pkg::ADDR_W-1:0] base_ff, base_in;
   logic                        rsp_tvalid_ff, rsp_tvalid_in;
   logic [31:0]                 rsp_tdata_ff, rsp_tdata_in;
   logic [1:0]                  rsp_tuser_ff, rsp_tuser_in;

   logic                        ram_we;
   logic [fbca_pkg::IDX_W-1:0]  ram_waddr;
   logic [fbca_pkg::ENT_W-1:0]  ram_wdata;
   logic                        ram_re;
   logic [fbca_pkg::IDX_W-1:0]  ram_raddr;
   logic [fbca_pkg::ENT_W-1:0]  ram_rdata;

   logic                        seq_valid;
   logic                        slot_free;
   fbca_pkg::rsp_type           seq_rsp;

   assign csr_ready = 1'b1;
   assign base_in   = csr_valid ? csr_wdata : base_ff;

   assign slot_free = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      if (seq_valid && slot_free) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {1'b0, seq_rsp.freed, seq_rsp.chain_end, seq_rsp.addr};
         rsp_tuser_in  = seq_rsp.status;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff       <= fbca_pkg::DATA_BASE_RESET;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         base_ff       <= base_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   fbca_ram #(
      .DEPTH (fbca_pkg::NUM_BLOCKS),
      .WIDTH (fbca_pkg::ENT_W)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   fbca_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_kind  (req_tuser),
      .req_addr  (req_tdata),
      .data_base (base_ff),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata),
      .rsp_valid (seq_valid),
      .rsp_take  (slot_free),
      .rsp       (seq_rsp)
   );

endmodule

@@ test/fat_block_chain_allocator_tb.sv @@
// self-checking bench for fat_block_chain_allocator: directed and random request words
// against a shadow allocation table, with sender gaps and receiver stalls in phases
// depends on fbca_pkg and the fat_block_chain_allocator rtl
module fat_block_chain_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [fbca_pkg::KIND_W-1:0] kind;
      logic [fbca_pkg::ADDR_W-1:0] addr;
   } fat_req_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // block_addr[15:0]
   logic [2:0]  req_tuser = '0;   // req_type[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // result_addr[15:0], chain_end[16], freed_count[30:17]
   logic [1:0]  rsp_tuser;        // status[1:0]
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_wdata = '0;

   fat_req_type         requests_todo[$];
   fbca_pkg::rsp_type   replies_due[$];
   fbca_pkg::entry_type fat_shadow[fbca_pkg::NUM_BLOCKS];
   logic [15:0]         base_shadow;
   int                  send_idle_pct = 0;
   int                  recv_stall_pct = 0;
   int                  fail_count = 0;

   fat_block_chain_allocator uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int lowest_free_entry();
      for (int i = 0; i < fbca_pkg::NUM_BLOCKS; i++)
         if (fat_shadow[i].tag == fbca_pkg::TAG_FREE)
            return i;
      return fbca_pkg::NUM_BLOCKS;
   endfunction

   // serves one request on the shadow table and returns the result word it should give
   function automatic fbca_pkg::rsp_type fat_serve(
         input logic [fbca_pkg::KIND_W-1:0] kind,
         input logic [fbca_pkg::ADDR_W-1:0] addr);
      fbca_pkg::rsp_type   r;
      logic [15:0]         off;
      logic                in_map;
      int                  idx;
      int                  nxt;
      fbca_pkg::entry_type e;
      r = '0;
      off = addr - base_shadow;
      in_map = (addr >= base_shadow) && (off < fbca_pkg::NUM_BLOCKS);
      idx = int'(off);
      case (kind)
         fbca_pkg::REQ_START: begin
            nxt = lowest_free_entry();
            if (nxt == fbca_pkg::NUM_BLOCKS) begin
               r.status = fbca_pkg::ST_FULL;
            end else begin
               fat_shadow[nxt].tag = fbca_pkg::TAG_END;
               r.addr = base_shadow + 16'(nxt);
               r.chain_end = 1'b1;
            end
         end
         fbca_pkg::REQ_APPEND, fbca_pkg::REQ_NEXT: begin
            if (!in_map) begin
               r.status = fbca_pkg::ST_RANGE;
            end else if (fat_shadow[idx].tag == fbca_pkg::TAG_FREE) begin
               r.status = fbca_pkg::ST_UNALLOC;
            end else if (fat_shadow[idx].tag == fbca_pkg::TAG_END) begin
               if (kind == fbca_pkg::REQ_NEXT) begin
                  r.addr = addr;
                  r.chain_end = 1'b1;
               end else begin
                  nxt = lowest_free_entry();
                  if (nxt == fbca_pkg::NUM_BLOCKS) begin
                     r.status = fbca_pkg::ST_FULL;
                  end else begin
                     fat_shadow[idx].tag = fbca_pkg::TAG_LINK;
                     fat_shadow[idx].link = fbca_pkg::IDX_W'(nxt);
                     fat_shadow[nxt].tag = fbca_pkg::TAG_END;
                     r.addr = base_shadow + 16'(nxt);
                     r.chain_end = 1'b1;
                  end
               end
            end else begin
               // linked entry: follow it, the target may already be free (stale link)
               nxt = int'(fat_shadow[idx].link);
               r.addr = base_shadow + 16'(nxt);
               r.chain_end = (fat_shadow[nxt].tag == fbca_pkg::TAG_END);
            end
         end
         fbca_pkg::REQ_FREE: begin
            if (!in_map) begin
               r.status = fbca_pkg::ST_RANGE;
            end else if (fat_shadow[idx].tag == fbca_pkg::TAG_FREE) begin
               r.status = fbca_pkg::ST_UNALLOC;
            end else begin
               r.addr = addr;
               while (fat_shadow[idx].tag != fbca_pkg::TAG_FREE) begin
                  e = fat_shadow[idx];
                  fat_shadow[idx].tag = fbca_pkg::TAG_FREE;
                  r.freed = r.freed + 1'b1;
                  if (e.tag == fbca_pkg::TAG_END)
                     break;
                  idx = int'(e.link);
               end
            end
         end
         fbca_pkg::REQ_FORMAT: begin
            for (int i = 0; i < fbca_pkg::NUM_BLOCKS; i++) begin
               if (fat_shadow[i].tag != fbca_pkg::TAG_FREE)
                  r.freed = r.freed + 1'b1;
               fat_shadow[i].tag = fbca_pkg::TAG_FREE;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input int got, input int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   // request driver; the shadow table follows every accepted word and csr write
   always @(posedge clock) begin : drive_requests
      fat_req_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
         for (int i = 0; i < fbca_pkg::NUM_BLOCKS; i++)
            fat_shadow[i] = '{tag: fbca_pkg::TAG_FREE, link: '0};
         base_shadow = fbca_pkg::DATA_BASE_RESET;
      end else begin
         if (csr_valid && csr_ready)
            base_shadow = csr_wdata;
         if (req_tvalid && req_tready)
            replies_due.push_back(fat_serve(req_tuser, req_tdata));
         if (!req_tvalid || req_tready) begin
            if (requests_todo.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               item = requests_todo.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= item.kind;
               req_tdata <= item.addr;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_replies
      fbca_pkg::rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
         if (rsp_tvalid && rsp_tready) begin
            if (replies_due.size() == 0) begin
               flag_mismatch("result word with none due, status", rsp_tuser, 0);
            end else begin
               want = replies_due.pop_front();
               if (rsp_tuser != want.status)
                  flag_mismatch("status", rsp_tuser, want.status);
               if (rsp_tdata[15:0] != want.addr)
                  flag_mismatch("result_addr", rsp_tdata[15:0], want.addr);
               if (rsp_tdata[16] != want.chain_end)
                  flag_mismatch("chain_end", rsp_tdata[16], want.chain_end);
               if (rsp_tdata[30:17] != want.freed)
                  flag_mismatch("freed_count", rsp_tdata[30:17], want.freed);
            end
         end
      end
   end

   task automatic add_req(input logic [fbca_pkg::KIND_W-1:0] kind,
                          input logic [fbca_pkg::ADDR_W-1:0] addr);
      fat_req_type item;
      item.kind = kind;
      item.addr = addr;
      requests_todo.push_back(item);
   endtask

   task automatic write_data_base(input logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_quiet();
      do @(negedge clock);
      while (requests_todo.size() != 0 || req_tvalid || replies_due.size() != 0);
   endtask

   // mostly requests on the low entries where first fit puts chains, some at the
   // range edges and some fully random words
   task automatic queue_random(input int count, input logic [15:0] base);
      logic [fbca_pkg::KIND_W-1:0] kind;
      logic [fbca_pkg::ADDR_W-1:0] addr;
      int                          pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 22)      kind = fbca_pkg::REQ_START;
         else if (pick < 50) kind = fbca_pkg::REQ_APPEND;
         else if (pick < 62) kind = fbca_pkg::REQ_FREE;
         else if (pick < 90) kind = fbca_pkg::REQ_NEXT;
         else if (pick < 92) kind = fbca_pkg::REQ_FORMAT;
         else if (pick < 95) kind = fbca_pkg::KIND_W'(5 + $urandom_range(0, 2));
         else                kind = fbca_pkg::REQ_NEXT;
         pick = $urandom_range(0, 99);
         if (pick < 78)
            addr = base + 16'($urandom_range(0, 47));
         else if (pick < 86)
            addr = base + 16'($urandom_range(fbca_pkg::NUM_BLOCKS - 2,
                                             fbca_pkg::NUM_BLOCKS));
         else if (pick < 90)
            addr = base - 16'($urandom_range(1, 2));
         else
            addr = 16'($urandom);
         add_req(kind, addr);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // no idling, base at its reset value, directed words first
      write_data_base(fbca_pkg::DATA_BASE_RESET);
      add_req(fbca_pkg::REQ_NEXT, 16'd512);          // free entry
      add_req(fbca_pkg::REQ_START, 16'd0);
      add_req(fbca_pkg::REQ_START, 16'hFFFF);
      add_req(fbca_pkg::REQ_APPEND, 16'd512);        // links a new block after a chain end
      add_req(fbca_pkg::REQ_APPEND, 16'd512);        // follows the existing link
      add_req(fbca_pkg::REQ_NEXT, 16'd512);
      add_req(fbca_pkg::REQ_NEXT, 16'd514);          // chain end names itself
      add_req(fbca_pkg::REQ_APPEND, 16'd514);
      add_req(fbca_pkg::REQ_NEXT, 16'd512);
      add_req(fbca_pkg::REQ_FREE, 16'd514);          // free from the middle of a chain
      add_req(fbca_pkg::REQ_NEXT, 16'd512);          // now a stale link
      add_req(fbca_pkg::REQ_FREE, 16'd512);          // walk stops at the stale link
      add_req(fbca_pkg::REQ_FREE, 16'd512);
      add_req(fbca_pkg::REQ_APPEND, 16'd512);
      add_req(fbca_pkg::REQ_NEXT, 16'd511);          // below base
      add_req(fbca_pkg::REQ_NEXT, 16'd512 + 16'(fbca_pkg::NUM_BLOCKS - 1));
      add_req(fbca_pkg::REQ_APPEND, 16'd512 + 16'(fbca_pkg::NUM_BLOCKS));
      add_req(fbca_pkg::REQ_FREE, 16'd0);
      add_req(fbca_pkg::REQ_NEXT, 16'hFFFF);
      add_req(fbca_pkg::REQ_START, 16'd0);
      add_req(fbca_pkg::REQ_APPEND, 16'd513);
      add_req(fbca_pkg::KIND_W'(5), 16'd513);
      add_req(fbca_pkg::KIND_W'(6), 16'hFFFF);
      add_req(fbca_pkg::KIND_W'(7), 16'd0);
      add_req(fbca_pkg::REQ_FORMAT, 16'd0);
      queue_random(19, fbca_pkg::DATA_BASE_RESET);

      // a full table takes far too many first-fit searches to reach here
      wait_quiet();
      send_idle_pct = 76;
      write_data_base(16'd0);
      queue_random(19, 16'd0);

      wait_quiet();
      send_idle_pct = 0;
      recv_stall_pct = 76;
      write_data_base(16'd57344);
      queue_random(19, 16'd57344);

      wait_quiet();
      send_idle_pct = 28;
      recv_stall_pct = 28;
      begin
         logic [15:0] mid_base;
         mid_base = 16'($urandom_range(1, 57343));
         write_data_base(mid_base);
         queue_random(19, mid_base);
      end

      wait_quiet();
      repeat (fbca_pkg::NUM_BLOCKS + 16) @(posedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // clearing pass plus every word at its slowest, several times over
   initial begin
      #50_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/fbca_pkg.sv
rtl/fbca_ram.sv
rtl/fbca_seq.sv
rtl/fat_block_chain_allocator.sv
test/fat_block_chain_allocator_tb.sv
